// ----- src/ssa_pkg.sv -----
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared widths, codes and controller/datapath types for the shadow slot
// allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int KEY_W          = 32;
    localparam int TIME_W         = 32;
    localparam int SLOT_IDX_W     = 4;
    localparam int OUTCOME_W      = 2;
    localparam int SLOT_COUNT_DEF = 16;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_HIT     = 2'd0,
        OUTCOME_FILL    = 2'd1,
        OUTCOME_REPLACE = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic start;    // latch request, clear scan trackers
        logic issue;    // read one slot, advance scan address
        logic commit;   // update table, load result register
    } ssa_cmd_t;

    typedef struct packed {
        logic last_addr;  // scan address is on the final slot
        logic out_free;   // result register can take a new result
    } ssa_status_t;

endpackage

// ----- src/ssa_req_if.sv -----
// ----------------------------------------------------------------------------
// ssa_req_if
// Request channel: owner key, change time and current time.
// ----------------------------------------------------------------------------
interface ssa_req_if;
    import ssa_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  owner_key;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output owner_key, output change_time,
                    output now_time, input ready);
    modport sink   (input valid, input owner_key, input change_time,
                    input now_time, output ready);
endinterface

// ----- src/ssa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ssa_rsp_if
// Response channel: assigned slot, redraw flag and lookup outcome.
// ----------------------------------------------------------------------------
interface ssa_rsp_if;
    import ssa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  redraw;
    logic [OUTCOME_W-1:0]  outcome;

    modport source (output valid, output slot_index, output redraw,
                    output outcome, input ready);
    modport sink   (input valid, input slot_index, input redraw,
                    input outcome, output ready);
endinterface

// ----- src/shadow_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// shadow_slot_allocator
// Fully associative slot table with oldest-stamp replacement: returns the
// slot for an owner key and whether its contents need a redraw.
//
//   channel | dir | payload                            | transfer
//   req     | in  | owner_key, change_time, now_time   | req.valid & req.ready
//   rsp     | out | slot_index, redraw, outcome        | rsp.valid & rsp.ready
//
// A request passes through the accept cycle, a read of every slot of the table,
// a drain of the read register and a commit.
// Reset clears every used bit and the control state; no clearing pass.
// A new request is taken while a result still waits in the output register;
// commit of that request stalls until the output register is free.
// ----------------------------------------------------------------------------
module shadow_slot_allocator #(
    parameter int SLOT_COUNT = ssa_pkg::SLOT_COUNT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ssa_req_if.sink   req,
    ssa_rsp_if.source rsp
);
    import ssa_pkg::*;

    ssa_cmd_t    cmd;
    ssa_status_t status;

    ssa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ssa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .owner_key   (req.owner_key),
        .change_time (req.change_time),
        .now_time    (req.now_time),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .slot_index  (rsp.slot_index),
        .redraw      (rsp.redraw),
        .outcome     (rsp.outcome)
    );

endmodule

// ----- src/ssa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssa_ctrl
// Sequencer: accept a request, scan every slot once, drain the read
// pipeline, then commit when the result register is free.
// ----------------------------------------------------------------------------
module ssa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ssa_pkg::ssa_status_t status,
    output ssa_pkg::ssa_cmd_t    cmd
);
    import ssa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last slot's read data is folded in this cycle
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.issue, cmd.commit}))
        else $error("ssa_ctrl: more than one command at once");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.last_addr) |=> state_reg == ST_DRAIN)
        else $error("ssa_ctrl: scan did not end on last slot");

    a_commit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && !status.out_free) |=> state_reg == ST_COMMIT)
        else $error("ssa_ctrl: left commit while result register busy");

endmodule

// ----- src/ssa_datapath.sv -----
// ----------------------------------------------------------------------------
// ssa_datapath
// Slot table storage, one-slot-per-cycle scan trackers (hit, first empty,
// oldest stamp), table update and result register.
// ----------------------------------------------------------------------------
module ssa_datapath #(
    parameter int SLOT_COUNT = ssa_pkg::SLOT_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssa_pkg::ssa_cmd_t              cmd,
    output ssa_pkg::ssa_status_t           status,
    input  logic [ssa_pkg::KEY_W-1:0]      owner_key,
    input  logic [ssa_pkg::TIME_W-1:0]     change_time,
    input  logic [ssa_pkg::TIME_W-1:0]     now_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ssa_pkg::SLOT_IDX_W-1:0] slot_index,
    output logic                           redraw,
    output logic [ssa_pkg::OUTCOME_W-1:0]  outcome
);
    import ssa_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // table storage
    logic [KEY_W-1:0]  key_mem   [SLOT_COUNT];
    logic [TIME_W-1:0] stamp_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] used_reg;

    // request
    logic [KEY_W-1:0]  req_key_reg;
    logic [TIME_W-1:0] req_change_reg;
    logic [TIME_W-1:0] req_now_reg;

    // scan pipeline
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_used_reg;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [TIME_W-1:0] rd_stamp_reg;
    logic [TIME_W-1:0] rd_stamp_eff;

    // trackers
    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [TIME_W-1:0] hit_stamp_reg;
    logic              empty_found_reg;
    logic [IDX_W-1:0]  empty_idx_reg;
    logic [IDX_W-1:0]  min_idx_reg;
    logic [TIME_W-1:0] min_stamp_reg;

    // selection
    logic [IDX_W-1:0]      sel_idx;
    logic [TIME_W-1:0]     sel_stamp;
    outcome_t              sel_outcome;
    logic                  sel_redraw;
    logic [IDX_W+SLOT_IDX_W-1:0] sel_idx_wide;

    // result register
    logic                  out_valid_reg;
    logic [SLOT_IDX_W-1:0] out_idx_reg;
    logic                  out_redraw_reg;
    outcome_t              out_outcome_reg;

    assign status.last_addr = (scan_idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign rd_stamp_eff = rd_used_reg ? rd_stamp_reg : '0;

    always_comb
    begin
        priority if (hit_found_reg)
        begin
            sel_idx     = hit_idx_reg;
            sel_stamp   = hit_stamp_reg;
            sel_outcome = OUTCOME_HIT;
        end
        else if (empty_found_reg)
        begin
            sel_idx     = empty_idx_reg;
            sel_stamp   = '0;
            sel_outcome = OUTCOME_FILL;
        end
        else
        begin
            sel_idx     = min_idx_reg;
            sel_stamp   = '0;
            sel_outcome = OUTCOME_REPLACE;
        end
        sel_redraw   = (req_change_reg >= sel_stamp);
        sel_idx_wide = {{SLOT_IDX_W{1'b0}}, sel_idx};
    end

    // request capture and scan address
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_key_reg    <= owner_key;
            req_change_reg <= change_time;
            req_now_reg    <= now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
            if (cmd.start || (cmd.issue && status.last_addr))
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // table memories: read during the scan, written at commit
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[scan_idx_reg];
        rd_stamp_reg <= stamp_mem[scan_idx_reg];
        rd_used_reg  <= used_reg[scan_idx_reg];
        rd_idx_reg   <= scan_idx_reg;
        if (cmd.commit)
        begin
            if (sel_outcome != OUTCOME_HIT)
            begin
                key_mem[sel_idx] <= req_key_reg;
            end
            if (sel_redraw)
            begin
                stamp_mem[sel_idx] <= req_now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.commit)
        begin
            used_reg[sel_idx] <= 1'b1;
        end
    end

    // scan trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_used_reg && rd_key_reg == req_key_reg)
            begin
                hit_found_reg <= 1'b1;
            end
            if (!rd_used_reg)
            begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (rd_used_reg && rd_key_reg == req_key_reg && !hit_found_reg)
            begin
                hit_idx_reg   <= rd_idx_reg;
                hit_stamp_reg <= rd_stamp_reg;
            end
            if (!rd_used_reg && !empty_found_reg)
            begin
                empty_idx_reg <= rd_idx_reg;
            end
            // strict less-than keeps the lowest index on ties
            if (rd_idx_reg == '0 || rd_stamp_eff < min_stamp_reg)
            begin
                min_idx_reg   <= rd_idx_reg;
                min_stamp_reg <= rd_stamp_eff;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_idx_reg     <= sel_idx_wide[SLOT_IDX_W-1:0];
            out_redraw_reg  <= sel_redraw;
            out_outcome_reg <= sel_outcome;
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_index = out_idx_reg;
    assign redraw     = out_redraw_reg;
    assign outcome    = out_outcome_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("ssa_datapath: commit over an untaken result");

    a_replace_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_found_reg && !empty_found_reg) |-> (&used_reg))
        else $error("ssa_datapath: replacement while a slot is empty");

    a_commit_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (used_reg != '0) && out_valid_reg)
        else $error("ssa_datapath: commit left no used slot or no result");

endmodule

// ----- tb/shadow_slot_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// shadow_slot_allocator_tb
// Self-checking bench for the slot allocator. A software copy of the slot
// table predicts slot, redraw and outcome for each accepted request; results
// are matched in order. Directed fill/hit/replace cases come first, then
// frame-like traffic over a small key pool with some random noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shadow_slot_allocator_tb;
    import ssa_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int SCAN_CYCLES  = SLOTS + 3;
    localparam int RANDOM_ITEMS = 1830;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  redraw;
        outcome_t              outcome;
    } slot_result_t;

    class slot_table_scoreboard;
        logic [KEY_W-1:0]  slot_key   [SLOTS];
        bit                slot_used  [SLOTS];
        logic [TIME_W-1:0] slot_stamp [SLOTS];
        slot_result_t      pending_q[$];
        int                errors;
        int                checked;
        int                hits;
        int                fills;
        int                replaces;
        int                redraws;

        function void note_request(input logic [KEY_W-1:0] key,
                                   input logic [TIME_W-1:0] changed,
                                   input logic [TIME_W-1:0] now_t);
            int           slot;
            slot_result_t res;
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot < 0 && slot_used[i] && slot_key[i] == key)
                    slot = i;
            end
            if (slot >= 0)
            begin
                res.outcome = OUTCOME_HIT;
                hits++;
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot < 0 && !slot_used[i])
                        slot = i;
                end
                if (slot >= 0)
                begin
                    res.outcome = OUTCOME_FILL;
                    fills++;
                end
                else
                begin
                    // oldest stamp wins, lowest index on ties
                    slot = 0;
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        if (slot_stamp[i] < slot_stamp[slot])
                            slot = i;
                    end
                    res.outcome = OUTCOME_REPLACE;
                    replaces++;
                end
                slot_used[slot]  = 1'b1;
                slot_key[slot]   = key;
                slot_stamp[slot] = '0;
            end
            res.redraw = (changed >= slot_stamp[slot]);
            if (res.redraw)
            begin
                slot_stamp[slot] = now_t;
                redraws++;
            end
            res.slot_index = slot[SLOT_IDX_W-1:0];
            pending_q.push_back(res);
        endfunction

        function void check_result(input logic [SLOT_IDX_W-1:0] idx,
                                   input logic redraw,
                                   input logic [OUTCOME_W-1:0] outcome);
            slot_result_t exp_res;
            checked++;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result: slot %0d redraw %0b outcome %0d",
                             $time, idx, redraw, outcome);
                return;
            end
            exp_res = pending_q.pop_front();
            if (idx !== exp_res.slot_index || redraw !== exp_res.redraw ||
                outcome !== exp_res.outcome)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch #%0d: exp slot %0d redraw %0b outcome %s, got slot %0d redraw %0b outcome %0d",
                             $time, checked, exp_res.slot_index, exp_res.redraw,
                             exp_res.outcome.name(), idx, redraw, outcome);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ssa_req_if req_ch ();
    ssa_rsp_if rsp_ch ();

    shadow_slot_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    slot_table_scoreboard sb;

    int                send_idle_pct;
    int                rsp_idle_pct;
    int                accepted;
    int                blocked_cycles;
    logic              stall_hold;
    logic              hold_done;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    logic [TIME_W-1:0] frame_time;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // sink side: check the transfer seen at this edge, then pick next ready
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.slot_index, rsp_ch.redraw, rsp_ch.outcome);
            if (stall_hold)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // long output stall so the block fills up and backs up its input
    initial
    begin
        stall_hold     <= 1'b0;
        hold_done      <= 1'b0;
        blocked_cycles = 0;
        wait (accepted >= 300);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES)
        begin
            @(posedge clk);
            if (req_ch.valid && !req_ch.ready)
                blocked_cycles++;
        end
        stall_hold <= 1'b0;
        hold_done  <= 1'b1;
    end

    task automatic send_request(input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] changed,
                                input logic [TIME_W-1:0] now_t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.owner_key <= $urandom;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.owner_key   <= key;
        req_ch.change_time <= changed;
        req_ch.now_time    <= now_t;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(key, changed, now_t);
        accepted++;
    endtask

    task automatic run_directed();
        send_request(32'h0, 32'h0, 32'h0);                      // fill slot 0
        send_request(32'h0, 32'h0, 32'd7);                      // hit, equal stamp
        send_request(32'h0, 32'd6, 32'd9);                      // hit, older change
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);      // hit, no redraw
        for (int i = 0; i < SLOTS - 2; i++)
            send_request(32'd100 + i, 32'h0, 32'h0);            // fill the rest
        send_request(32'hA5A5_5A5A, 32'd5, 32'd3);              // tie on stamp 0
        send_request(32'h5A5A_A5A5, 32'h0, 32'h0);
        send_request(32'd100, 32'd1, 32'd2);                    // evicted key misses
        send_request(32'hA5A5_5A5A, 32'd2, 32'd4);              // hit, change < stamp
    endtask

    task automatic run_traffic(input int count);
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] changed;
        logic [TIME_W-1:0] now_t;
        int                back;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 85)
            begin
                // frame traffic: hot owners, time moves forward
                if ($urandom_range(99) < 70)
                    key = key_pool[$urandom_range(11)];
                else
                    key = key_pool[$urandom_range(POOL_SIZE - 1)];
                frame_time = frame_time + $urandom_range(3);
                now_t = frame_time;
                back  = $urandom_range(12);
                case ($urandom_range(3))
                    0, 1: changed = frame_time;
                    2: changed = (frame_time > back) ? frame_time - back : '0;
                    default: changed = frame_time + $urandom_range(2);
                endcase
            end
            else
            begin
                key     = $urandom;
                changed = $urandom;
                now_t   = $urandom_range(2) == 0 ? $urandom : frame_time;
            end
            send_request(key, changed, now_t);
        end
    endtask

    initial
    begin
        int waited;
        sb       = new;
        accepted = 0;
        rst_n    <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.owner_key   <= '0;
        req_ch.change_time <= '0;
        req_ch.now_time    <= '0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[3] = key_pool[2] ^ 32'h8000_0001;   // near-miss keys
        frame_time  = $urandom_range(32'h4000_0000);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        rsp_idle_pct  = 86;
        run_directed();
        run_traffic(RANDOM_ITEMS / 3);

        send_idle_pct = 86;
        rsp_idle_pct  = 30;
        run_traffic(RANDOM_ITEMS / 3);

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        run_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        req_ch.valid <= 1'b0;

        waited = 0;
        while ((sb.pending() != 0 || !hold_done) && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * SCAN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        $display("Ran %0d requests: %0d hits, %0d fills, %0d replacements, %0d redraws.",
                 accepted, sb.hits, sb.fills, sb.replaces, sb.redraws);
        $display("Input held back %0d cycles during a %0d-cycle output stall; %0d mismatches.",
                 blocked_cycles, HOLD_CYCLES, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
